// ===== src/pmm_pkg.sv =====
// Shared types, codes and helpers for the packed triangular matrix product core.
package pmm_pkg;

   localparam int unsigned IndexWidth = 12;
   localparam int unsigned CoordWidth = 6;
   localparam int unsigned ElemWidth  = 16;
   localparam int unsigned ProdWidth  = 32;
   localparam int unsigned SumWidth   = 38;
   localparam int unsigned SizeWidth  = 7;

   localparam logic [SizeWidth-1:0] SizeReset = 7'd64;

   localparam logic [0:0] OP_LOAD  = 1'b0;
   localparam logic [0:0] OP_QUERY = 1'b1;

   localparam logic [0:0] STATUS_OK    = 1'b0;
   localparam logic [0:0] STATUS_RANGE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // One read issue toward the datapath, plus the out-of-range reply request.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic err;
   } issue_type;

   // Start of row or column i in packed storage: i(i+1)/2.
   function automatic logic [IndexWidth-1:0] tri_base(input logic [CoordWidth-1:0] i);
      logic [IndexWidth:0] p;
      p = (IndexWidth+1)'(i) * (IndexWidth+1)'({1'b0, i} + 7'd1);
      return p[IndexWidth:1];
   endfunction

endpackage

// ===== src/pmm_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module pmm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 2080,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pmm_ctrl.sv =====
// Sequencer: accepts beats, writes loads, walks the packed addresses of a query.
module pmm_ctrl #(
   parameter int MAX_N  = 64,
   parameter int DEPTH  = MAX_N * (MAX_N + 1) / 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [0:0]                             operation,
   input  logic [pmm_pkg::IndexWidth-1:0]         packed_index,
   input  logic [pmm_pkg::CoordWidth-1:0]         row,
   input  logic [pmm_pkg::CoordWidth-1:0]         col,
   input  logic [pmm_pkg::SizeWidth-1:0]          eff_size,
   input  logic                                   rsp_done,
   output logic                                   wr_en,
   output logic [ADDR_W-1:0]                      wr_addr,
   output logic                                   rd_en,
   output logic [ADDR_W-1:0]                      rd_addr_a,
   output logic [ADDR_W-1:0]                      rd_addr_b,
   output pmm_pkg::issue_type                     issue
);

   pmm_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0] addr_a_ff, addr_a_in;
   logic [ADDR_W-1:0] addr_b_ff, addr_b_in;
   logic [pmm_pkg::CoordWidth-1:0] cnt_ff, cnt_in;
   logic first_ff, first_in;
   logic err_ff, err_in;
   logic out_of_range;
   logic in_store;

   assign out_of_range = ({1'b0, row} >= eff_size) || ({1'b0, col} >= eff_size);
   assign in_store     = 32'(packed_index) < 32'(DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmm_pkg::ST_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      cnt_ff    <= cnt_in;
      first_ff  <= first_in;
   end

   always_comb begin
      state_in  = state_ff;
      addr_a_in = addr_a_ff;
      addr_b_in = addr_b_ff;
      cnt_in    = cnt_ff;
      first_in  = first_ff;
      err_in    = 1'b0;
      wr_en     = 1'b0;
      issue     = '0;
      busy      = (state_ff != pmm_pkg::ST_IDLE);
      case (state_ff)
         pmm_pkg::ST_IDLE: begin
            if (start) begin
               if (operation == pmm_pkg::OP_LOAD) begin
                  wr_en = in_store;
               end else if (out_of_range) begin
                  err_in   = 1'b1;
                  state_in = pmm_pkg::ST_DRAIN;
               end else begin
                  addr_a_in = ADDR_W'(pmm_pkg::tri_base(row));
                  addr_b_in = ADDR_W'(pmm_pkg::tri_base(col));
                  cnt_in    = (row < col) ? row : col;
                  first_in  = 1'b1;
                  state_in  = pmm_pkg::ST_RUN;
               end
            end
         end
         pmm_pkg::ST_RUN: begin
            issue.valid = 1'b1;
            issue.first = first_ff;
            issue.last  = (cnt_ff == '0);
            first_in    = 1'b0;
            addr_a_in   = addr_a_ff + ADDR_W'(1);
            addr_b_in   = addr_b_ff + ADDR_W'(1);
            cnt_in      = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = pmm_pkg::ST_DRAIN;
            end
         end
         pmm_pkg::ST_DRAIN: begin
            if (rsp_done) begin
               state_in = pmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pmm_pkg::ST_IDLE;
         end
      endcase
      issue.err = err_ff;
   end

   assign wr_addr   = ADDR_W'(packed_index);
   assign rd_en     = (state_ff == pmm_pkg::ST_RUN);
   assign rd_addr_a = addr_a_ff;
   assign rd_addr_b = addr_b_ff;

endmodule

// ===== src/pmm_mac.sv =====
// Multiply-accumulate datapath behind the RAM read ports, with the result register.
module pmm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  pmm_pkg::issue_type                  issue,
   input  logic [pmm_pkg::ElemWidth-1:0]       a_data,
   input  logic [pmm_pkg::ElemWidth-1:0]       b_data,
   output logic                                rsp_valid,
   output logic [pmm_pkg::SumWidth-1:0]        rsp_sum,
   output logic [0:0]                          rsp_status
);

   pmm_pkg::issue_type s1_ff, s1_in;
   pmm_pkg::issue_type s2_ff, s2_in;
   logic [pmm_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic [pmm_pkg::SumWidth-1:0]  acc_ff, acc_in;
   logic [pmm_pkg::SumWidth-1:0]  sum_next;
   logic                          valid_ff, valid_in;
   logic [pmm_pkg::SumWidth-1:0]  sum_ff, sum_in;
   logic [0:0]                    status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff    <= '0;
         s2_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         valid_ff <= valid_in;
      end
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
   end

   always_comb begin
      // Stage 1 lines up with the registered RAM data.
      s1_in     = issue;
      s1_in.err = 1'b0;
      s2_in     = s1_ff;
      prod_in   = s1_ff.valid ? (pmm_pkg::ProdWidth'(a_data) * pmm_pkg::ProdWidth'(b_data))
                              : prod_ff;
      sum_next  = (s2_ff.first ? '0 : acc_ff) + pmm_pkg::SumWidth'(prod_ff);
      acc_in    = s2_ff.valid ? sum_next : acc_ff;
      valid_in  = issue.err | (s2_ff.valid & s2_ff.last);
      sum_in    = sum_ff;
      status_in = status_ff;
      if (issue.err) begin
         sum_in    = '0;
         status_in = pmm_pkg::STATUS_RANGE;
      end else if (s2_ff.valid && s2_ff.last) begin
         sum_in    = sum_next;
         status_in = pmm_pkg::STATUS_OK;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sum    = sum_ff;
   assign rsp_status = status_ff;

endmodule

// ===== src/packed_triangular_matmul_core.sv =====
// Top level of the packed triangular matrix product core (C = A * B, A lower, B upper).
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ---------------------------------
//   request  req_operation, req_packed_index,        beat taken on start & !busy
//            req_a_value, req_b_value, req_row,
//            req_col
//   result   rsp_row_out, rsp_col_out,               beat shown one cycle, rsp_valid
//            rsp_product_sum, rsp_status
//   config   csr_wr_en, csr_wr_data (size_in_use)    written on csr_wr_en, no wait
//
// A load beat writes both stores at the accepting edge if its packed index is in
// range, and leaves busy low: one beat per cycle while no query is in flight. A query
// walks min(row, col) + 1 packed entry pairs, one read of each RAM per cycle, and
// keeps busy high through its result beat. An out-of-range query replies through the
// error flag and result registers, then frees the block. Reset (synchronous, active
// high) clears the control state and sets size_in_use to 64; the stores are not
// cleared. The result beat cannot be held off, so the query walk never stalls.
module packed_triangular_matmul_core #(
   parameter int MAX_N = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [0:0]                           req_operation,
   input  logic [pmm_pkg::IndexWidth-1:0]       req_packed_index,
   input  logic [pmm_pkg::ElemWidth-1:0]        req_a_value,
   input  logic [pmm_pkg::ElemWidth-1:0]        req_b_value,
   input  logic [pmm_pkg::CoordWidth-1:0]       req_row,
   input  logic [pmm_pkg::CoordWidth-1:0]       req_col,
   // result channel
   output logic                                 rsp_valid,
   output logic [pmm_pkg::CoordWidth-1:0]       rsp_row_out,
   output logic [pmm_pkg::CoordWidth-1:0]       rsp_col_out,
   output logic [pmm_pkg::SumWidth-1:0]         rsp_product_sum,
   output logic [0:0]                           rsp_status,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [pmm_pkg::SizeWidth-1:0]        csr_wr_data
);

   localparam int Depth = MAX_N * (MAX_N + 1) / 2;
   localparam int AddrW = $clog2(Depth);

   logic [pmm_pkg::SizeWidth-1:0]  size_ff, size_in;
   logic [pmm_pkg::SizeWidth-1:0]  eff_size;
   logic [pmm_pkg::CoordWidth-1:0] row_ff, row_in;
   logic [pmm_pkg::CoordWidth-1:0] col_ff, col_in;

   logic                           wr_en;
   logic [AddrW-1:0]               wr_addr;
   logic                           rd_en;
   logic [AddrW-1:0]               rd_addr_a;
   logic [AddrW-1:0]               rd_addr_b;
   logic [pmm_pkg::ElemWidth-1:0]  a_data;
   logic [pmm_pkg::ElemWidth-1:0]  b_data;
   pmm_pkg::issue_type             issue;
   logic                           accept;

   // Size register: take every write, clamp on use.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= pmm_pkg::SizeReset;
      end else begin
         size_ff <= size_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
   end

   assign accept = start & ~busy;

   always_comb begin
      size_in = csr_wr_en ? csr_wr_data : size_ff;
      // Hold the query coordinates for the echo on the result beat.
      row_in  = row_ff;
      col_in  = col_ff;
      if (accept && req_operation == pmm_pkg::OP_QUERY) begin
         row_in = req_row;
         col_in = req_col;
      end
      // Zero acts as one, anything above MAX_N acts as MAX_N.
      if (size_ff == '0) begin
         eff_size = 7'd1;
      end else if (int'(size_ff) > MAX_N) begin
         eff_size = pmm_pkg::SizeWidth'(MAX_N);
      end else begin
         eff_size = size_ff;
      end
   end

   pmm_ctrl #(
      .MAX_N  (MAX_N),
      .DEPTH  (Depth),
      .ADDR_W (AddrW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .operation    (req_operation),
      .packed_index (req_packed_index),
      .row          (req_row),
      .col          (req_col),
      .eff_size     (eff_size),
      .rsp_done     (rsp_valid),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .rd_en        (rd_en),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .issue        (issue)
   );

   // A store, packed by rows.
   pmm_ram #(
      .WIDTH  (pmm_pkg::ElemWidth),
      .DEPTH  (Depth),
      .ADDR_W (AddrW)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_a_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   // B store, packed by columns.
   pmm_ram #(
      .WIDTH  (pmm_pkg::ElemWidth),
      .DEPTH  (Depth),
      .ADDR_W (AddrW)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_b_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   pmm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .a_data     (a_data),
      .b_data     (b_data),
      .rsp_valid  (rsp_valid),
      .rsp_sum    (rsp_product_sum),
      .rsp_status (rsp_status)
   );

   assign rsp_row_out = row_ff;
   assign rsp_col_out = col_ff;

endmodule

// ===== src/pmm_checker.sv =====
// Port-level assertions for the packed triangular matrix product core, with its bind.
module pmm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [0:0]                           req_operation,
   input logic                                 rsp_valid,
   input logic [pmm_pkg::SumWidth-1:0]         rsp_product_sum,
   input logic [0:0]                           rsp_status
);

   // A result beat only comes out of a query still in flight.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result beat while idle");

   // One query gives one result beat, never two in a row.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   // An out-of-range reply carries a zero sum.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pmm_pkg::STATUS_RANGE) |-> (rsp_product_sum == '0))
      else $error("range error with nonzero sum");

   // A query beat makes the block busy; a load beat does not.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == pmm_pkg::OP_QUERY) |=> busy)
      else $error("query accepted without going busy");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == pmm_pkg::OP_LOAD) |=> !busy)
      else $error("load beat left the block busy");

endmodule

bind packed_triangular_matmul_core pmm_checker u_pmm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_product_sum (rsp_product_sum),
   .rsp_status      (rsp_status)
);
